// File: src/ntc_adc_to_temperature_defines.svh
// Assertion macros for the thermistor conversion block.
`ifndef NTC_ADC_TO_TEMPERATURE_DEFINES_SVH
`define NTC_ADC_TO_TEMPERATURE_DEFINES_SVH
`ifndef SYNTHESIS
`define NTC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("ntc check failed");
`define NTC_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("ntc reset check failed");
`else
`define NTC_ASSERT(label, prop)
`define NTC_ASSERT_RST(label, prop)
`endif
`endif

// File: src/ntc_pkg.sv
// Types, constants and segment tables for the thermistor conversion block.
`default_nettype none
package ntc_pkg;
  localparam int unsigned DVD_W = 32;
  localparam int unsigned DSR_W = 20;
  localparam int unsigned TAG_W = 9;
  localparam int unsigned N_SEG = 7;

  localparam logic [15:0] FULL_SCALE = 16'd55708;
  localparam logic [15:0] R_DIVIDER  = 16'd49900;
  localparam logic [7:0]  FAULT_TEMP = 8'h9D;

  // Segments, highest resistance first
  localparam logic [31:0] SEG_LO [N_SEG] = '{32'd540000, 32'd320000, 32'd198000,
                                             32'd125000, 32'd80000, 32'd53300, 32'd35800};
  localparam logic [DSR_W-1:0] SEG_SPAN [N_SEG] = '{20'd400000, 20'd220000, 20'd122000,
                                                   20'd73000, 20'd45000, 20'd26700, 20'd17500};
  localparam logic [7:0] SEG_BASE [N_SEG] = '{8'hF6, 8'd0, 8'd10, 8'd20, 8'd30, 8'd40, 8'd50};
  localparam logic [31:0]      LAST_HI   = 32'd35800;
  localparam logic [DSR_W-1:0] LAST_SPAN = 20'd11100;
  localparam logic [7:0]       LAST_BASE = 8'd50;

  // One divider stage: partial remainder, dividend shifting out as quotient shifts in
  typedef struct packed {
    logic             vld;
    logic [DSR_W-1:0] rem;
    logic [DVD_W-1:0] dvd;
    logic [DSR_W-1:0] dsr;
    logic [TAG_W-1:0] tag;   // first divider: bit 0 fault; second: {add, base}
  } div_stage_t;
endpackage
`default_nettype wire

// File: src/ntc_div_cell.sv
// One restoring division cell: produces one quotient bit per item.
`default_nettype none
module ntc_div_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  ntc_pkg::div_stage_t d_i,
  output ntc_pkg::div_stage_t d_o
);
  import ntc_pkg::*;
  logic [DSR_W:0] rem_sh;
  logic [DSR_W:0] diff;
  logic           qbit;
  div_stage_t     stage_nxt;
  div_stage_t     stage_r;
  logic           vld_r;

  always_comb begin
    rem_sh = {d_i.rem, d_i.dvd[DVD_W-1]};
    diff   = rem_sh - {1'b0, d_i.dsr};
    qbit   = !diff[DSR_W];
    stage_nxt     = d_i;
    stage_nxt.rem = qbit ? diff[DSR_W-1:0] : rem_sh[DSR_W-1:0];
    stage_nxt.dvd = {d_i.dvd[DVD_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= stage_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r <= stage_nxt;
    end
  end

  always_comb begin
    d_o     = stage_r;
    d_o.vld = vld_r;
  end
endmodule
`default_nettype wire

// File: src/ntc_div_chain.sv
// Row of division cells, one quotient bit per cell.
`default_nettype none
module ntc_div_chain (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  ntc_pkg::div_stage_t d_i,
  output ntc_pkg::div_stage_t d_o
);
  import ntc_pkg::*;
  div_stage_t link [DVD_W+1];

  assign link[0] = d_i;
  for (genvar i = 0; i < DVD_W; i++) begin : g_cell
    ntc_div_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .d_i(link[i]), .d_o(link[i+1])
    );
  end
  assign d_o = link[DVD_W];
endmodule
`default_nettype wire

// File: src/ntc_seg.sv
// Segment selection: picks the resistance segment and sets up the second division.
`default_nettype none
module ntc_seg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  ntc_pkg::div_stage_t d_i,
  output ntc_pkg::div_stage_t d_o
);
  import ntc_pkg::*;
  logic [31:0] r;
  logic [31:0] off;
  logic [31:0] num;
  div_stage_t  stage_nxt;
  div_stage_t  stage_r;
  logic        vld_r;

  always_comb begin
    r   = {d_i.dvd[DVD_W-2:0], 1'b0};   // doubled resistance, wraps
    off = LAST_HI - r;
    stage_nxt     = d_i;
    stage_nxt.rem = '0;
    stage_nxt.dsr = LAST_SPAN;
    stage_nxt.tag = {1'b1, LAST_BASE};
    for (int i = N_SEG - 1; i >= 0; i--) begin
      if (r >= SEG_LO[i]) begin
        off           = r - SEG_LO[i];
        stage_nxt.dsr = SEG_SPAN[i];
        stage_nxt.tag = {1'b0, SEG_BASE[i]};
      end
    end
    num = {off[28:0], 3'b000} + {off[30:0], 1'b0};   // 10x, wraps
    stage_nxt.dvd = num;
    if (d_i.tag[0]) begin
      stage_nxt.dvd = '0;
      stage_nxt.dsr = DSR_W'(1);
      stage_nxt.tag = {1'b0, FAULT_TEMP};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= d_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r <= stage_nxt;
    end
  end

  always_comb begin
    d_o     = stage_r;
    d_o.vld = vld_r;
  end
endmodule
`default_nettype wire

// File: src/ntc_adc_to_temperature.sv
// Top level: thermistor ADC code to whole-degree Celsius temperature.
`default_nettype none
// Converts a 16-bit thermistor divider code to a signed 8-bit temperature in
// degrees C. Codes at or above full scale (55708) give -99 (0x9D). One code is
// taken every cycle unless the output register is stalled; each code passes the
// input register, 32 cells of the resistance divider, the segment stage,
// 32 cells of the interpolation divider and the output register. Each divider
// cell resolves one quotient bit. The whole pipeline holds while the output
// register is full and not taken, so in_tready follows out_tready.
// No reset-time sweep; results appear only for accepted codes.
`include "ntc_adc_to_temperature_defines.svh"
module ntc_adc_to_temperature (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [15:0] adc_code
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata    // [7:0] temperature_c
);
  import ntc_pkg::*;
  logic        en;
  logic        fault;
  div_stage_t  in_nxt;
  div_stage_t  in_r;
  logic        in_vld_r;
  div_stage_t  in_stage;
  div_stage_t  q1;
  div_stage_t  seg;
  div_stage_t  q2;
  logic [7:0]  temp_nxt;
  logic [7:0]  temp_r;
  logic        out_vld_r;

  // pipeline advances unless the result register is stalled
  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  always_comb begin
    fault      = in_tdata >= FULL_SCALE;
    in_nxt.vld = in_tvalid;
    in_nxt.rem = '0;
    in_nxt.dvd = DVD_W'(in_tdata) * DVD_W'(R_DIVIDER);   // below 2^32 for non-fault codes
    in_nxt.dsr = DSR_W'(FULL_SCALE - in_tdata);
    in_nxt.tag = {{(TAG_W-1){1'b0}}, fault};
    if (fault) begin
      in_nxt.dvd = '0;
      in_nxt.dsr = DSR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (en) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_r <= in_nxt;
    end
  end

  always_comb begin
    in_stage     = in_r;
    in_stage.vld = in_vld_r;
  end

  // resistance = code * 49900 / (full scale - code)
  ntc_div_chain u_div_r (.clk(clk), .rst_n(rst_n), .en(en), .d_i(in_stage), .d_o(q1));

  ntc_seg u_seg (.clk(clk), .rst_n(rst_n), .en(en), .d_i(q1), .d_o(seg));

  // fraction inside the segment
  ntc_div_chain u_div_f (.clk(clk), .rst_n(rst_n), .en(en), .d_i(seg), .d_o(q2));

  assign temp_nxt = q2.tag[TAG_W-1] ? q2.tag[7:0] + q2.dvd[7:0] : q2.tag[7:0] - q2.dvd[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= q2.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      temp_r <= temp_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = temp_r;

  `NTC_ASSERT_RST(a_rst_clears, !rst_n |=> !out_tvalid)
  `NTC_ASSERT(a_ready_follows, in_tready == (!out_tvalid || out_tready))
  `NTC_ASSERT(a_stall_blocks_in, (out_tvalid && !out_tready) |-> !in_tready)
endmodule
`default_nettype wire

// File: verif/ntc_temperature_checker.sv
// Checker: predicts thermistor temperatures and compares the result stream.
`timescale 1ns / 100ps
module ntc_temperature_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  output int          fail_count,
  output int          pending_count,
  output int          seen_count
);
  import ntc_pkg::*;

  logic [7:0] temps_due [$];

  // Interpolate downwards inside one segment, 32-bit wrap throughout
  function automatic logic [31:0] seg_temp(logic [31:0] base, logic [31:0] r,
                                           logic [31:0] lo, logic [31:0] hi);
    logic [31:0] prod;
    prod = 32'd10 * (r - lo);
    return base - prod / (hi - lo);
  endfunction

  function automatic logic [7:0] code_to_temp(logic [15:0] code);
    logic [31:0] c, r, t;
    c = {16'd0, code};
    if (c >= 32'd55708) return 8'h9D;
    r = (c * 32'd49900) / (32'd55708 - c);
    r = r << 1;
    if (r >= 32'd540000) t = seg_temp(32'hFFFF_FFF6, r, 32'd540000, 32'd940000);
    else if (r >= 32'd320000) t = seg_temp(32'd0, r, 32'd320000, 32'd540000);
    else if (r >= 32'd198000) t = seg_temp(32'd10, r, 32'd198000, 32'd320000);
    else if (r >= 32'd125000) t = seg_temp(32'd20, r, 32'd125000, 32'd198000);
    else if (r >= 32'd80000) t = seg_temp(32'd30, r, 32'd80000, 32'd125000);
    else if (r >= 32'd53300) t = seg_temp(32'd40, r, 32'd53300, 32'd80000);
    else if (r >= 32'd35800) t = seg_temp(32'd50, r, 32'd35800, 32'd53300);
    else t = 32'd50 + (32'd10 * (32'd35800 - r)) / 32'd11100;
    return t[7:0];
  endfunction

  initial begin
    fail_count = 0;
    seen_count = 0;
  end
  assign pending_count = temps_due.size();

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) temps_due.push_back(code_to_temp(in_tdata));
      if (out_tvalid && out_tready) begin
        seen_count <= seen_count + 1;
        if (temps_due.size() == 0) begin
          $error("temperature_c: unexpected result %0d", $signed(out_tdata));
          fail_count <= fail_count + 1;
        end else if (temps_due[0] != out_tdata) begin
          $error("temperature_c: expected %0d, actual %0d",
                 $signed(temps_due[0]), $signed(out_tdata));
          fail_count <= fail_count + 1;
          void'(temps_due.pop_front());
        end else begin
          void'(temps_due.pop_front());
        end
      end
    end
  end
endmodule

// File: verif/testbench.sv
// Testbench top: stimulus, idling and verdict for the thermistor converter.
`timescale 1ns / 100ps
module testbench;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  int          fail_count, pending_count, seen_count;

  // receiver idle percentage and long hold-off request
  int          rx_idle_pct = 64;
  bit          rx_hold = 1'b0;
  int          tx_idle_pct = 27;
  int          sent = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  ntc_adc_to_temperature DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  ntc_temperature_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending_count(pending_count), .seen_count(seen_count)
  );

  // Receiver: random stalls, or held low while a long hold-off is on
  always @(posedge clk) begin
    if (rx_hold) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Offer one code; hold tvalid until the transfer, gaps before it at random
  task automatic send_code(logic [15:0] code);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= code;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  // Random code: mostly the useful range, some near and above full scale
  function automatic logic [15:0] rand_code();
    int sel;
    sel = $urandom_range(9);
    if (sel < 6) return 16'($urandom_range(55707));
    if (sel == 6) return 16'($urandom_range(55707, 55000));
    if (sel == 7) return 16'($urandom_range(3000));
    return 16'($urandom_range(65535, 55708));
  endfunction

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  logic [15:0] directed [] = '{16'd0, 16'd1, 16'hFFFF, 16'd55708, 16'd55707, 16'd55706,
    16'd55700, 16'd55709, 16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA, 16'd10000,
    16'd20000, 16'd27854, 16'd35000, 16'd40000, 16'd45000, 16'd50000, 16'd52000,
    16'd54000, 16'd55000, 16'd500, 16'd5000, 16'd15000};

  initial begin
    int phase, i;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[k]) send_code(directed[k]);
    // Pressure: long receiver hold-off while codes keep coming
    rx_hold = 1'b1;
    tx_idle_pct = 0;
    fork
      begin
        for (i = 0; i < 100; i++) send_code(rand_code());
      end
      begin
        repeat (300) @(posedge clk);
        rx_hold = 1'b0;
      end
    join
    // Sender pause until everything has come back
    wait_drain();
    for (phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 64 : 0;
      rx_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 27 : 0;
      for (i = 0; i < 175; i++) send_code(rand_code());
    end
    wait_drain();
    repeat (100) @(posedge clk);
    $display("Run covered %0d codes (extremes, full-scale fault, wrap region), %0d results.",
             sent, seen_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("testbench: errors");
    $finish;
  end
endmodule
